// ===== hdl/ups_status_monitor_macros.svh =====
// Assertion macros for the checker file of the UPS status monitor.
`ifndef UPS_STATUS_MONITOR_MACROS_SVH
`define UPS_STATUS_MONITOR_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define UMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define UMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ums_pkg.sv =====
package ums_pkg;

  // Timer counters saturate at all ones of this width.
  localparam int TIMER_W = 16;
  // Configuration registers are 16 bits wide.
  localparam int CFG_W = 16;
  // Common width for comparing a counter with a register.
  localparam int CMP_W = (TIMER_W > CFG_W) ? TIMER_W : CFG_W;
  localparam int PREFIX_LEN = 5;
  localparam int PREFIX_W = 8 * PREFIX_LEN;
  localparam int NUM_PREFIX = 8;

  typedef logic [TIMER_W-1:0] tcount_t;
  typedef logic [CFG_W-1:0] cfg_word_t;
  localparam tcount_t TMAX = '1;
  localparam logic [7:0] CHAR_NL = 8'h0A;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SHUTDOWN_TIMEOUT = 2'd0,
    CFG_POWER_GOOD_DELAY = 2'd1,
    CFG_SWITCH_OFF_DELAY = 2'd2,
    CFG_WATCHDOG_TIMEOUT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    cfg_word_t shutdown_timeout;
    cfg_word_t power_good_delay;
    cfg_word_t switch_off_delay;
    cfg_word_t watchdog_timeout;
  } cfg_t;

  // Operation handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_LINE = 2'd1,
    OP_TICK = 2'd2
  } op_kind_t;

  // Recognized status lines, in matching order.
  typedef enum logic [2:0] {
    HIT_BUFRD    = 3'd0,
    HIT_ALARM    = 3'd1,
    HIT_DC_OK    = 3'd2,
    HIT_DC_LO    = 3'd3,
    HIT_ONLINE   = 3'd4,
    HIT_BAT      = 3'd5,
    HIT_FULL     = 3'd6,
    HIT_NOT_FULL = 3'd7
  } hit_t;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_READY    = 4'd1,
    EV_ALARM    = 4'd2,
    EV_DC_OK    = 4'd3,
    EV_DC_LOW   = 4'd4,
    EV_ONLINE   = 4'd5,
    EV_ISLAND   = 4'd6,
    EV_FULL     = 4'd7,
    EV_NOT_FULL = 4'd8
  } line_event_t;

  typedef struct packed {
    op_kind_t kind;
    hit_t     hit;
    logic     sw;
  } op_t;

  // Result item, line event in the lowest bits.
  typedef struct packed {
    logic        shutdown_commanded;
    logic        link_ok;
    logic        storage_full;
    logic        on_battery;
    logic        dc_input_ok;
    logic        buffer_ready;
    logic        switch_off_event;
    logic        power_good_again;
    logic        power_loss_shutdown;
    logic        comm_failure;
    line_event_t line_event;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  // Five-character status prefixes, first character in the lowest byte.
  function automatic logic [PREFIX_W-1:0] prefix_of(hit_t h);
    logic [PREFIX_W-1:0] p;
    unique case (h)
      HIT_BUFRD:    p = 40'h44_52_46_55_42;
      HIT_ALARM:    p = 40'h4D_52_41_4C_41;
      HIT_DC_OK:    p = 40'h4B_4F_5F_43_44;
      HIT_DC_LO:    p = 40'h4F_4C_5F_43_44;
      HIT_ONLINE:   p = 40'h2A_2A_2A_2A_2A;
      HIT_BAT:      p = 40'h2A_54_41_42_2A;
      HIT_FULL:     p = 40'h35_38_3E_41_42;
      HIT_NOT_FULL: p = 40'h35_38_3C_41_42;
      default:      p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/ums_front.sv =====
module ums_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          command,
  input  logic [7:0]    rx_byte,
  input  logic          switch_on,
  output ums_pkg::op_t  op
);
  import ums_pkg::*;

  logic [PREFIX_W-1:0] prefix_r;
  logic [2:0]          count_r;
  logic                hit_found;
  hit_t                hit_code;

  // Compare the collected prefix with every known status line.
  always_comb begin
    hit_found = 1'b0;
    hit_code  = HIT_BUFRD;
    for (int k = NUM_PREFIX - 1; k >= 0; k--) begin
      if (prefix_r == prefix_of(hit_t'(k))) begin
        hit_found = 1'b1;
        hit_code  = hit_t'(k);
      end
    end
    if (count_r < 3'(PREFIX_LEN)) begin
      hit_found = 1'b0;
    end
  end

  // Classify the incoming transfer.
  always_comb begin
    op.sw   = switch_on;
    op.hit  = hit_code;
    op.kind = OP_NOP;
    if (command) begin
      op.kind = OP_TICK;
    end else if (rx_byte == CHAR_NL && hit_found) begin
      op.kind = OP_LINE;
    end
  end

  // Collect the first characters of the current line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
      count_r  <= '0;
    end else if (accept && !command) begin
      if (rx_byte == CHAR_NL) begin
        prefix_r <= '0;
        count_r  <= '0;
      end else if (count_r < 3'(PREFIX_LEN)) begin
        prefix_r[count_r*8 +: 8] <= rx_byte;
        count_r                  <= count_r + 3'd1;
      end
    end
  end

endmodule

// ===== hdl/ums_opq.sv =====
module ums_opq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ums_pkg::op_t  push_op,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output ums_pkg::op_t  pop_op
);
  import ums_pkg::*;

  op_t        slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_op    = slot_r[rd_ptr_r];

  // Two-entry queue between classification and execution.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== hdl/ums_back.sv =====
module ums_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ums_pkg::cfg_t      cfg,
  input  logic               op_valid,
  input  ums_pkg::op_t       op,
  output logic               op_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ums_pkg::result_t   result
);
  import ums_pkg::*;

  function automatic tcount_t inc_sat(tcount_t v);
    return (v == TMAX) ? v : v + tcount_t'(1);
  endfunction

  function automatic logic reached(tcount_t c, cfg_word_t r);
    return CMP_W'(c) >= CMP_W'(r);
  endfunction

  logic    ready_r, ready_nxt;
  logic    full_r, full_nxt;
  logic    island_r, island_nxt;
  logic    dc_r, dc_nxt;
  logic    alive_r, alive_nxt;
  tcount_t wd_cnt_r, wd_cnt_nxt;
  tcount_t sd_cnt_r, sd_cnt_nxt;
  logic    sd_run_r, sd_run_nxt;
  tcount_t good_cnt_r, good_cnt_nxt;
  logic    good_run_r, good_run_nxt;
  logic    sw_prev_r, sw_prev_nxt;
  tcount_t off_cnt_r, off_cnt_nxt;
  logic    off_timing_r, off_timing_nxt;
  logic    off_sig_r, off_sig_nxt;
  logic    latch_r, latch_nxt;
  logic    out_valid_r;
  result_t result_r, result_nxt;

  assign op_pop    = op_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign result    = result_r;

  // Execute one operation on the flags and timers.
  always_comb begin
    ready_nxt      = ready_r;
    full_nxt       = full_r;
    island_nxt     = island_r;
    dc_nxt         = dc_r;
    alive_nxt      = alive_r;
    wd_cnt_nxt     = wd_cnt_r;
    sd_cnt_nxt     = sd_cnt_r;
    sd_run_nxt     = sd_run_r;
    good_cnt_nxt   = good_cnt_r;
    good_run_nxt   = good_run_r;
    sw_prev_nxt    = sw_prev_r;
    off_cnt_nxt    = off_cnt_r;
    off_timing_nxt = off_timing_r;
    off_sig_nxt    = off_sig_r;
    latch_nxt      = latch_r;
    result_nxt     = '0;
    result_nxt.line_event = EV_NONE;

    unique case (op.kind)
      OP_LINE: begin
        unique case (op.hit)
          HIT_BUFRD: begin
            if (!ready_r) begin
              ready_nxt = 1'b1;
              result_nxt.line_event = EV_READY;
            end
          end
          HIT_ALARM: begin
            if (ready_r) begin
              ready_nxt = 1'b0;
              result_nxt.line_event = EV_ALARM;
            end
          end
          HIT_DC_OK: begin
            if (!dc_r) begin
              dc_nxt       = 1'b1;
              good_cnt_nxt = '0;
              good_run_nxt = 1'b1;
              result_nxt.line_event = EV_DC_OK;
            end
          end
          HIT_DC_LO: begin
            if (dc_r) begin
              dc_nxt       = 1'b0;
              good_run_nxt = 1'b0;
              result_nxt.line_event = EV_DC_LOW;
            end
          end
          HIT_ONLINE: begin
            if (island_r) begin
              island_nxt = 1'b0;
              result_nxt.line_event = EV_ONLINE;
            end
          end
          HIT_BAT: begin
            if (!island_r) begin
              island_nxt = 1'b1;
              result_nxt.line_event = EV_ISLAND;
            end
          end
          HIT_FULL: begin
            if (!full_r) begin
              full_nxt   = 1'b1;
              sd_run_nxt = 1'b0;
              result_nxt.line_event = EV_FULL;
            end
          end
          HIT_NOT_FULL: begin
            if (full_r) begin
              full_nxt   = 1'b0;
              sd_cnt_nxt = '0;
              sd_run_nxt = 1'b1;
              result_nxt.line_event = EV_NOT_FULL;
            end
          end
          default: ;
        endcase
        alive_nxt  = 1'b1;
        wd_cnt_nxt = '0;
      end

      OP_TICK: begin
        // Repeating communication watchdog.
        wd_cnt_nxt = inc_sat(wd_cnt_r);
        if (reached(wd_cnt_nxt, cfg.watchdog_timeout)) begin
          result_nxt.comm_failure = 1'b1;
          alive_nxt  = 1'b0;
          wd_cnt_nxt = '0;
        end
        // Single-shot shutdown timer, checked before the power-good timer.
        if (sd_run_r) begin
          sd_cnt_nxt = inc_sat(sd_cnt_r);
          if (reached(sd_cnt_nxt, cfg.shutdown_timeout)) begin
            result_nxt.power_loss_shutdown = 1'b1;
            sd_run_nxt = 1'b0;
            latch_nxt  = 1'b1;
          end
        end
        // Single-shot power-good timer; its expiry also stops the shutdown timer.
        if (good_run_r) begin
          good_cnt_nxt = inc_sat(good_cnt_r);
          if (reached(good_cnt_nxt, cfg.power_good_delay)) begin
            result_nxt.power_good_again = 1'b1;
            good_run_nxt = 1'b0;
            sd_run_nxt   = 1'b0;
          end
        end
        // Main switch edges and off delay.
        if (op.sw != sw_prev_r) begin
          if (!op.sw) begin
            off_cnt_nxt    = '0;
            off_timing_nxt = 1'b1;
          end else begin
            off_sig_nxt    = 1'b0;
            off_timing_nxt = 1'b0;
          end
          sw_prev_nxt = op.sw;
        end else if (!op.sw && off_timing_r) begin
          off_cnt_nxt = inc_sat(off_cnt_r);
        end
        if (!op.sw && off_timing_nxt && !off_sig_nxt &&
            (CMP_W'(off_cnt_nxt) > CMP_W'(cfg.switch_off_delay))) begin
          off_sig_nxt = 1'b1;
          latch_nxt   = 1'b1;
          result_nxt.switch_off_event = 1'b1;
        end
      end

      default: ;
    endcase

    result_nxt.buffer_ready       = ready_nxt;
    result_nxt.dc_input_ok        = dc_nxt;
    result_nxt.on_battery         = island_nxt;
    result_nxt.storage_full       = full_nxt;
    result_nxt.link_ok            = alive_nxt;
    result_nxt.shutdown_commanded = latch_nxt;
  end

  // State registers advance once per executed operation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r      <= 1'b0;
      full_r       <= 1'b0;
      island_r     <= 1'b0;
      dc_r         <= 1'b1;
      alive_r      <= 1'b1;
      wd_cnt_r     <= '0;
      sd_cnt_r     <= '0;
      sd_run_r     <= 1'b0;
      good_cnt_r   <= '0;
      good_run_r   <= 1'b0;
      sw_prev_r    <= 1'b0;
      off_cnt_r    <= '0;
      off_timing_r <= 1'b0;
      off_sig_r    <= 1'b0;
      latch_r      <= 1'b0;
    end else if (op_pop) begin
      ready_r      <= ready_nxt;
      full_r       <= full_nxt;
      island_r     <= island_nxt;
      dc_r         <= dc_nxt;
      alive_r      <= alive_nxt;
      wd_cnt_r     <= wd_cnt_nxt;
      sd_cnt_r     <= sd_cnt_nxt;
      sd_run_r     <= sd_run_nxt;
      good_cnt_r   <= good_cnt_nxt;
      good_run_r   <= good_run_nxt;
      sw_prev_r    <= sw_prev_nxt;
      off_cnt_r    <= off_cnt_nxt;
      off_timing_r <= off_timing_nxt;
      off_sig_r    <= off_sig_nxt;
      latch_r      <= latch_nxt;
    end
  end

  // Output register holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (op_pop) begin
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== hdl/ups_status_monitor.sv =====
// A result passes through the queue and then the output register before it is offered.
// Throughput: one item per cycle unless the output stalls; the back end executes one queued operation per cycle.
// A two-entry queue and the output register let input and output stall independently.
// Reset (rst_n low, synchronous) clears the line buffer, queue, flags and timers,
// sets dc_input_ok and link_ok, and loads the default configuration values.
module ups_status_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [8] switch_on
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] line_event, [4] comm_failure, [5] power_loss_shutdown,
  // [6] power_good_again, [7] switch_off_event, [8] buffer_ready,
  // [9] dc_input_ok, [10] on_battery, [11] storage_full, [12] link_ok,
  // [13] shutdown_commanded
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import ums_pkg::*;

  cfg_t    cfg_r;
  logic    in_accept;
  op_t     front_op;
  logic    q_not_empty;
  op_t     q_op;
  logic    q_pop;
  result_t result;

  assign in_accept = in_tvalid && in_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shutdown_timeout <= 16'd30000;
      cfg_r.power_good_delay <= 16'd5000;
      cfg_r.switch_off_delay <= 16'd500;
      cfg_r.watchdog_timeout <= 16'd5000;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SHUTDOWN_TIMEOUT: cfg_r.shutdown_timeout <= cfg_wdata;
        CFG_POWER_GOOD_DELAY: cfg_r.power_good_delay <= cfg_wdata;
        CFG_SWITCH_OFF_DELAY: cfg_r.switch_off_delay <= cfg_wdata;
        CFG_WATCHDOG_TIMEOUT: cfg_r.watchdog_timeout <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ums_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .command   (in_tuser),
    .rx_byte   (in_tdata[7:0]),
    .switch_on (in_tdata[8]),
    .op        (front_op)
  );

  ums_opq u_opq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_op   (front_op),
    .not_full  (in_tready),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_op    (q_op)
  );

  ums_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .op_valid  (q_not_empty),
    .op        (q_op),
    .op_pop    (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  assign out_tdata = {(16 - RESULT_W)'(0), result};

endmodule

// ===== hdl/ums_checker.sv =====
`include "ups_status_monitor_macros.svh"

module ums_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result holds its value.
  `UMS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Once commanded, shutdown stays set in every later result.
  `UMS_ASSERT_NEXT(a_shutdown_sticky, out_tvalid && out_tdata[13], !out_tvalid || out_tdata[13], "shutdown command dropped")

  // A watchdog expiry reports the link as lost.
  `UMS_ASSERT_NOW(a_comm_fail_link, out_tvalid && out_tdata[4], !out_tdata[12], "link_ok set on comm failure")

  // Shutdown timer expiry or switch-off event commands shutdown.
  `UMS_ASSERT_NOW(a_shutdown_cause, out_tvalid && (out_tdata[5] || out_tdata[7]), out_tdata[13], "shutdown cause without command")

endmodule

bind ups_status_monitor ums_checker u_ums_checker (.*);
